### src/lav_pkg.sv
// ----------------------------------------------------------------------------
// lav_pkg
// Types, constants and helpers shared by the look-at view matrix unit.
// ----------------------------------------------------------------------------
package lav_pkg;

  localparam int FRAC   = 16;              // fraction bits of Q16.16
  localparam int WORD   = 32;              // saturation width of results
  localparam int SCL_HI = 30;              // scaled top magnitude below 2^30
  localparam int SCL_LO = 29;              // and at least 2^29
  localparam int M_W    = 50;              // magnitude register width
  localparam int UN_W   = FRAC + 2;        // signed unit component
  localparam int TU_W   = FRAC + 4;        // signed true-up component
  localparam int Q_W    = FRAC + 1;        // unsigned quotient
  localparam int LEN_W  = SCL_HI + 1;      // vector length
  localparam int NUM_W  = SCL_HI + 1 + FRAC;
  localparam int SUM_W  = 2 * SCL_HI + 2;  // sum of three squares
  localparam int OP_W   = 33;              // multiplier operand
  localparam int ACC_W  = 64;              // accumulator
  localparam int PC_W   = 5;

  localparam logic [WORD-1:0] ONE = WORD'(64'(1) << FRAC);

  localparam logic [PC_W-1:0] PC_SIDE = PC_W'(0);
  localparam logic [PC_W-1:0] PC_SQ   = PC_W'(6);
  localparam logic [PC_W-1:0] PC_REST = PC_W'(9);

  typedef struct packed {
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [31:0] at_x;
    logic signed [31:0] at_y;
    logic signed [31:0] at_z;
    logic signed [31:0] up_x;
    logic signed [31:0] up_y;
    logic signed [31:0] up_z;
  } lav_req_t;

  typedef struct packed {
    logic [1:0]         row_index;
    logic signed [31:0] col_zero;
    logic signed [31:0] col_one;
    logic signed [31:0] col_two;
    logic signed [31:0] col_three;
    logic               degenerate;
    logic               last_row;
  } lav_rsp_t;

  typedef struct packed {
    logic [2:0][31:0] eye;
    logic [2:0][31:0] up;
    logic [2:0][32:0] diff;
    logic             degen;
  } lav_job_t;

  typedef struct packed {
    logic [2:0][UN_W-1:0] side;
    logic [2:0][TU_W-1:0] tup;
    logic [2:0][UN_W-1:0] fwd;
    logic [2:0][WORD-1:0] dot;
    logic                 degen;
  } lav_mat_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCALE, ST_MAC, ST_SQRT, ST_DIVGO, ST_DIV, ST_DONE
  } lav_state_t;

  typedef enum logic [1:0] {SG_SIDE, SG_SQ, SG_REST} lav_seg_t;

  typedef enum logic [2:0] {
    SRC_EYE, SRC_UP, SRC_FWD, SRC_SIDE, SRC_TUP, SRC_MAG
  } lav_src_t;

  typedef enum logic [2:0] {DST_NONE, DST_RAWM, DST_SUM, DST_TUP, DST_DOT} lav_dst_t;

  typedef struct packed {
    lav_src_t   sa;
    logic [1:0] ia;
    lav_src_t   sb;
    logic [1:0] ib;
    logic       neg;
    logic       last;
    lav_dst_t   dst;
    logic [1:0] di;
    logic       seg_end;
  } lav_op_t;

  function automatic lav_op_t mk_op(input lav_src_t sa, input logic [1:0] ia,
                                    input lav_src_t sb, input logic [1:0] ib,
                                    input logic neg, input logic last,
                                    input lav_dst_t dst, input logic [1:0] di,
                                    input logic seg_end);
    lav_op_t o;
    o.sa = sa; o.ia = ia; o.sb = sb; o.ib = ib;
    o.neg = neg; o.last = last; o.dst = dst; o.di = di; o.seg_end = seg_end;
    return o;
  endfunction

  // multiply-accumulate programme: side cross product, squares, true up,
  // then the three eye dot products
  function automatic lav_op_t lav_prog(input logic [PC_W-1:0] pc);
    lav_op_t o;
    case (pc)
      5'd0:  o = mk_op(SRC_UP, 2'd1, SRC_FWD, 2'd2, 1'b0, 1'b0, DST_NONE, 2'd0, 1'b0);
      5'd1:  o = mk_op(SRC_UP, 2'd2, SRC_FWD, 2'd1, 1'b1, 1'b1, DST_RAWM, 2'd0, 1'b0);
      5'd2:  o = mk_op(SRC_UP, 2'd2, SRC_FWD, 2'd0, 1'b0, 1'b0, DST_NONE, 2'd0, 1'b0);
      5'd3:  o = mk_op(SRC_UP, 2'd0, SRC_FWD, 2'd2, 1'b1, 1'b1, DST_RAWM, 2'd1, 1'b0);
      5'd4:  o = mk_op(SRC_UP, 2'd0, SRC_FWD, 2'd1, 1'b0, 1'b0, DST_NONE, 2'd0, 1'b0);
      5'd5:  o = mk_op(SRC_UP, 2'd1, SRC_FWD, 2'd0, 1'b1, 1'b1, DST_RAWM, 2'd2, 1'b1);
      5'd6:  o = mk_op(SRC_MAG, 2'd0, SRC_MAG, 2'd0, 1'b0, 1'b0, DST_NONE, 2'd0, 1'b0);
      5'd7:  o = mk_op(SRC_MAG, 2'd1, SRC_MAG, 2'd1, 1'b0, 1'b0, DST_NONE, 2'd0, 1'b0);
      5'd8:  o = mk_op(SRC_MAG, 2'd2, SRC_MAG, 2'd2, 1'b0, 1'b1, DST_SUM, 2'd0, 1'b1);
      5'd9:  o = mk_op(SRC_FWD, 2'd1, SRC_SIDE, 2'd2, 1'b0, 1'b0, DST_NONE, 2'd0, 1'b0);
      5'd10: o = mk_op(SRC_FWD, 2'd2, SRC_SIDE, 2'd1, 1'b1, 1'b1, DST_TUP, 2'd0, 1'b0);
      5'd11: o = mk_op(SRC_FWD, 2'd2, SRC_SIDE, 2'd0, 1'b0, 1'b0, DST_NONE, 2'd0, 1'b0);
      5'd12: o = mk_op(SRC_FWD, 2'd0, SRC_SIDE, 2'd2, 1'b1, 1'b1, DST_TUP, 2'd1, 1'b0);
      5'd13: o = mk_op(SRC_FWD, 2'd0, SRC_SIDE, 2'd1, 1'b0, 1'b0, DST_NONE, 2'd0, 1'b0);
      5'd14: o = mk_op(SRC_FWD, 2'd1, SRC_SIDE, 2'd0, 1'b1, 1'b1, DST_TUP, 2'd2, 1'b0);
      5'd15: o = mk_op(SRC_EYE, 2'd0, SRC_SIDE, 2'd0, 1'b0, 1'b0, DST_NONE, 2'd0, 1'b0);
      5'd16: o = mk_op(SRC_EYE, 2'd1, SRC_SIDE, 2'd1, 1'b0, 1'b0, DST_NONE, 2'd0, 1'b0);
      5'd17: o = mk_op(SRC_EYE, 2'd2, SRC_SIDE, 2'd2, 1'b0, 1'b1, DST_DOT, 2'd0, 1'b0);
      5'd18: o = mk_op(SRC_EYE, 2'd0, SRC_FWD, 2'd0, 1'b0, 1'b0, DST_NONE, 2'd0, 1'b0);
      5'd19: o = mk_op(SRC_EYE, 2'd1, SRC_FWD, 2'd1, 1'b0, 1'b0, DST_NONE, 2'd0, 1'b0);
      5'd20: o = mk_op(SRC_EYE, 2'd2, SRC_FWD, 2'd2, 1'b0, 1'b1, DST_DOT, 2'd2, 1'b0);
      5'd21: o = mk_op(SRC_EYE, 2'd0, SRC_TUP, 2'd0, 1'b0, 1'b0, DST_NONE, 2'd0, 1'b0);
      5'd22: o = mk_op(SRC_EYE, 2'd1, SRC_TUP, 2'd1, 1'b0, 1'b0, DST_NONE, 2'd0, 1'b0);
      5'd23: o = mk_op(SRC_EYE, 2'd2, SRC_TUP, 2'd2, 1'b0, 1'b1, DST_DOT, 2'd1, 1'b1);
      default: o = mk_op(SRC_EYE, 2'd0, SRC_EYE, 2'd0, 1'b0, 1'b0, DST_NONE, 2'd0, 1'b1);
    endcase
    return o;
  endfunction

  function automatic logic [OP_W-1:0] pick3(input logic [2:0][OP_W-1:0] v,
                                            input logic [1:0] i);
    logic [OP_W-1:0] r;
    case (i)
      2'd0:    r = v[0];
      2'd1:    r = v[1];
      default: r = v[2];
    endcase
    return r;
  endfunction

  // shift right by FRAC, rounding half away from zero
  function automatic logic signed [ACC_W-1:0] round_shift(input logic signed [ACC_W-1:0] x);
    logic [ACC_W-1:0] m;
    m = x[ACC_W-1] ? ACC_W'(-x) : ACC_W'(x);
    m = (m + (ACC_W'(1) << (FRAC - 1))) >> FRAC;
    return x[ACC_W-1] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [WORD-1:0] sat_word(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    logic signed [ACC_W-1:0] r;
    hi = $signed((ACC_W'(1) << (WORD - 1)) - ACC_W'(1));
    lo = $signed(~hi);
    if (x > hi) begin
      r = hi;
    end else if (x < lo) begin
      r = lo;
    end else begin
      r = x;
    end
    return r[WORD-1:0];
  endfunction

endpackage

### src/lav_front.sv
// ----------------------------------------------------------------------------
// lav_front
// Takes request items, forms at minus eye and flags eye equal to at.
// ----------------------------------------------------------------------------
module lav_front import lav_pkg::*; (
  input  logic     req_valid,
  output logic     req_ready,
  input  lav_req_t req,
  input  logic     full,
  output logic     push,
  output lav_job_t job
);

  assign req_ready = ~full;
  assign push      = req_valid & ~full;

  always_comb begin
    job.eye[0]  = req.eye_x;
    job.eye[1]  = req.eye_y;
    job.eye[2]  = req.eye_z;
    job.up[0]   = req.up_x;
    job.up[1]   = req.up_y;
    job.up[2]   = req.up_z;
    job.diff[0] = 33'(req.at_x) - 33'(req.eye_x);
    job.diff[1] = 33'(req.at_y) - 33'(req.eye_y);
    job.diff[2] = 33'(req.at_z) - 33'(req.eye_z);
    job.degen   = (req.at_x == req.eye_x) && (req.at_y == req.eye_y) &&
                  (req.at_z == req.eye_z);
  end

endmodule

### src/lav_fifo.sv
// ----------------------------------------------------------------------------
// lav_fifo
// Two-entry queue of classified items between front and back.
// ----------------------------------------------------------------------------
module lav_fifo import lav_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  lav_job_t job_in,
  output logic     full,
  input  logic     pop,
  output lav_job_t job_out,
  output logic     avail
);

  lav_job_t   mem [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;

  assign full    = cnt == 2'd2;
  assign avail   = cnt != 2'd0;
  assign job_out = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= job_in;
    end
  end

endmodule

### src/lav_sqrt.sv
// ----------------------------------------------------------------------------
// lav_sqrt
// Integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module lav_sqrt import lav_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] value,
  output logic             done,
  output logic [LEN_W-1:0] root
);

  localparam int RW = SUM_W + 2;

  logic          busy;
  logic [RW-1:0] v;
  logic [RW-1:0] res;
  logic [RW-1:0] bitv;
  logic [RW-1:0] t;
  logic          ge;

  assign t    = res + bitv;
  assign ge   = v >= t;
  assign root = res[LEN_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && bitv[0]) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v    <= RW'(value);
      res  <= '0;
      bitv <= RW'(1) << (2 * (SUM_W / 2) - 2);
    end else if (busy) begin
      if (ge) begin
        v   <= v - t;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

endmodule

### src/lav_div.sv
// ----------------------------------------------------------------------------
// lav_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lav_div import lav_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [LEN_W-1:0] den,
  output logic             done,
  output logic [Q_W-1:0]   quo
);

  localparam int CNT_W = $clog2(Q_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [LEN_W-1:0] rem;
  logic [Q_W-1:0]   nlow;
  logic [LEN_W:0]   trial;
  logic             ge;

  assign trial = {rem, nlow[Q_W-1]};
  assign ge    = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(Q_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= LEN_W'(num[NUM_W-1:Q_W]);
      nlow <= num[Q_W-1:0];
      quo  <= '0;
    end else if (busy) begin
      rem  <= ge ? LEN_W'(trial - {1'b0, den}) : trial[LEN_W-1:0];
      quo  <= {quo[Q_W-2:0], ge};
      nlow <= nlow << 1;
    end
  end

endmodule

### src/lav_back.sv
// ----------------------------------------------------------------------------
// lav_back
// Sequencer: normalises forward and side axes, forms true up and the eye
// dot products on one shared multiply-accumulate path.
// ----------------------------------------------------------------------------
module lav_back import lav_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     job_avail,
  input  lav_job_t job,
  output logic     job_pop,
  input  logic     emit_busy,
  output logic     mat_load,
  output lav_mat_t mat
);

  lav_state_t state;
  lav_state_t state_next;
  lav_seg_t   seg;
  lav_seg_t   seg_next;
  logic       mac_go;
  logic       sqrt_start;
  logic       div_start;

  logic                 norm_side;
  logic                 degen;
  logic [1:0]           comp;
  logic [2:0][31:0]     eye;
  logic [2:0][31:0]     up;
  logic [2:0][M_W-1:0]  m;
  logic [2:0]           sg;
  logic [2:0][UN_W-1:0] fwd;
  logic [2:0][UN_W-1:0] side;
  logic [2:0][TU_W-1:0] tup;
  logic [2:0][WORD-1:0] dot;
  logic [SUM_W-1:0]     sumsq;
  logic [LEN_W-1:0]     len;

  logic [PC_W-1:0]         pc;
  logic                    issuing;
  logic signed [ACC_W-1:0] prod;
  logic                    pv;
  logic                    p_neg;
  logic                    p_last;
  lav_dst_t                p_dst;
  logic [1:0]              p_di;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] res;
  logic                    rv;
  lav_dst_t                r_dst;
  logic [1:0]              r_di;

  lav_op_t                 opc;
  logic [2:0][OP_W-1:0]    eye_o, up_o, fwd_o, side_o, tup_o, mag_o;
  logic [2:0][OP_W-1:0]    va, vb;
  logic signed [OP_W-1:0]  a, b;
  logic signed [2*OP_W-1:0] pfull;
  logic signed [ACC_W-1:0] sum;
  logic signed [ACC_W-1:0] rs;
  logic                    drained;

  logic [M_W-1:0]   top;
  logic             in_range;
  logic [M_W-1:0]   m_sel;
  logic             sg_sel;
  logic [NUM_W-1:0] div_num;
  logic             sqrt_done;
  logic [LEN_W-1:0] root;
  logic             div_done;
  logic [Q_W-1:0]   quo;
  logic [UN_W-1:0]  qe;
  logic [UN_W-1:0]  qs;

  lav_sqrt u_sqrt (
    .clk  (clk),
    .rst  (rst),
    .start(sqrt_start),
    .value(sumsq),
    .done (sqrt_done),
    .root (root)
  );

  lav_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (len),
    .done (div_done),
    .quo  (quo)
  );

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      eye_o[k]  = OP_W'($signed(eye[k]));
      up_o[k]   = OP_W'($signed(up[k]));
      fwd_o[k]  = OP_W'($signed(fwd[k]));
      side_o[k] = OP_W'($signed(side[k]));
      tup_o[k]  = OP_W'($signed(tup[k]));
      mag_o[k]  = OP_W'(m[k][SCL_HI-1:0]);
    end
    opc = lav_prog(pc);
    case (opc.sa)
      SRC_EYE:  va = eye_o;
      SRC_UP:   va = up_o;
      SRC_FWD:  va = fwd_o;
      SRC_SIDE: va = side_o;
      SRC_TUP:  va = tup_o;
      SRC_MAG:  va = mag_o;
      default:  va = '0;
    endcase
    case (opc.sb)
      SRC_EYE:  vb = eye_o;
      SRC_UP:   vb = up_o;
      SRC_FWD:  vb = fwd_o;
      SRC_SIDE: vb = side_o;
      SRC_TUP:  vb = tup_o;
      SRC_MAG:  vb = mag_o;
      default:  vb = '0;
    endcase
    a = $signed(pick3(va, opc.ia));
    b = $signed(pick3(vb, opc.ib));
  end

  assign pfull   = a * b;
  assign sum     = acc + (p_neg ? -prod : prod);
  assign rs      = round_shift(res);
  assign drained = ~issuing & ~pv & ~rv;

  always_comb begin
    top = m[0];
    if (m[1] > top) begin
      top = m[1];
    end
    if (m[2] > top) begin
      top = m[2];
    end
    in_range = ~(|top[M_W-1:SCL_HI]) & top[SCL_LO];
  end

  always_comb begin
    case (comp)
      2'd0:    begin m_sel = m[0]; sg_sel = sg[0]; end
      2'd1:    begin m_sel = m[1]; sg_sel = sg[1]; end
      default: begin m_sel = m[2]; sg_sel = sg[2]; end
    endcase
    div_num = NUM_W'({m_sel[SCL_HI-1:0], {FRAC{1'b0}}}) + NUM_W'(len >> 1);
    qe      = UN_W'(quo);
    qs      = sg_sel ? -qe : qe;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    seg_next   = SG_SIDE;
    job_pop    = 1'b0;
    mac_go     = 1'b0;
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    mat_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (job_avail) begin
          job_pop    = 1'b1;
          state_next = job.degen ? ST_DONE : ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (top == '0) begin
          state_next = ST_DONE;
        end else if (in_range) begin
          mac_go     = 1'b1;
          seg_next   = SG_SQ;
          state_next = ST_MAC;
        end
      end
      ST_MAC: begin
        if (drained) begin
          case (seg)
            SG_SIDE: state_next = ST_SCALE;
            SG_SQ: begin
              sqrt_start = 1'b1;
              state_next = ST_SQRT;
            end
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_SQRT: begin
        if (sqrt_done) begin
          state_next = ST_DIVGO;
        end
      end
      ST_DIVGO: begin
        div_start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          if (comp == 2'd2) begin
            mac_go     = 1'b1;
            seg_next   = norm_side ? SG_REST : SG_SIDE;
            state_next = ST_MAC;
          end else begin
            state_next = ST_DIVGO;
          end
        end
      end
      ST_DONE: begin
        if (!emit_busy) begin
          mat_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // multiply-accumulate control
  always_ff @(posedge clk) begin
    if (rst) begin
      issuing <= 1'b0;
      pv      <= 1'b0;
      rv      <= 1'b0;
    end else begin
      pv <= issuing;
      rv <= pv & p_last;
      if (issuing && opc.seg_end) begin
        issuing <= 1'b0;
      end
      if (mac_go) begin
        issuing <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      eye       <= job.eye;
      up        <= job.up;
      degen     <= job.degen;
      norm_side <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        m[k]  <= M_W'(job.diff[k][32] ? 33'(-$signed(job.diff[k])) : job.diff[k]);
        sg[k] <= job.diff[k][32];
      end
    end
    if (state == ST_SCALE) begin
      if (top == '0) begin
        degen <= 1'b1;
      end else if (|top[M_W-1:SCL_HI+7]) begin
        for (int k = 0; k < 3; k++) m[k] <= m[k] >> 8;
      end else if (|top[M_W-1:SCL_HI]) begin
        for (int k = 0; k < 3; k++) m[k] <= m[k] >> 1;
      end else if (~(|top[M_W-1:SCL_LO-8])) begin
        for (int k = 0; k < 3; k++) m[k] <= m[k] << 8;
      end else if (!top[SCL_LO]) begin
        for (int k = 0; k < 3; k++) m[k] <= m[k] << 1;
      end
    end
    if (issuing) begin
      prod   <= pfull[ACC_W-1:0];
      p_neg  <= opc.neg;
      p_last <= opc.last;
      p_dst  <= opc.dst;
      p_di   <= opc.di;
      pc     <= pc + 1'b1;
    end
    if (pv) begin
      if (p_last) begin
        res <= sum;
        acc <= '0;
      end else begin
        acc <= sum;
      end
      r_dst <= p_dst;
      r_di  <= p_di;
    end
    if (rv) begin
      case (r_dst)
        DST_RAWM: begin
          m[r_di]  <= M_W'(res[ACC_W-1] ? -res : res);
          sg[r_di] <= res[ACC_W-1];
        end
        DST_SUM: sumsq       <= res[SUM_W-1:0];
        DST_TUP: tup[r_di]   <= rs[TU_W-1:0];
        DST_DOT: dot[r_di]   <= sat_word(-rs);
        default: ;
      endcase
    end
    if (mac_go) begin
      seg <= seg_next;
      acc <= '0;
      case (seg_next)
        SG_SIDE: pc <= PC_SIDE;
        SG_SQ:   pc <= PC_SQ;
        default: pc <= PC_REST;
      endcase
      if (seg_next == SG_SIDE) begin
        norm_side <= 1'b1;
      end
    end
    if (sqrt_start) begin
      comp <= 2'd0;
    end
    if (sqrt_done) begin
      len <= root;
    end
    if (div_done) begin
      if (norm_side) begin
        side[comp] <= qs;
      end else begin
        fwd[comp] <= qs;
      end
      comp <= comp + 1'b1;
    end
  end

  always_comb begin
    mat.side  = side;
    mat.tup   = tup;
    mat.fwd   = fwd;
    mat.dot   = dot;
    mat.degen = degen;
  end

endmodule

### src/lav_emit.sv
// ----------------------------------------------------------------------------
// lav_emit
// Holds one finished matrix and sends it as four row items.
// ----------------------------------------------------------------------------
module lav_emit import lav_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     load,
  input  lav_mat_t mat_in,
  output logic     busy,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output lav_rsp_t rsp
);

  lav_mat_t   mat;
  logic [1:0] row;

  assign rsp_valid = busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      row  <= 2'd0;
    end else if (load) begin
      busy <= 1'b1;
      row  <= 2'd0;
    end else if (busy && rsp_ready) begin
      if (row == 2'd3) begin
        busy <= 1'b0;
      end
      row <= row + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mat <= mat_in;
    end
  end

  always_comb begin
    rsp.row_index  = row;
    rsp.degenerate = mat.degen;
    rsp.last_row   = row == 2'd3;
    rsp.col_three  = '0;
    case (row)
      2'd0: begin
        rsp.col_zero = sat_word(ACC_W'($signed(mat.side[0])));
        rsp.col_one  = sat_word(ACC_W'($signed(mat.tup[0])));
        rsp.col_two  = sat_word(ACC_W'($signed(mat.fwd[0])));
      end
      2'd1: begin
        rsp.col_zero = sat_word(ACC_W'($signed(mat.side[1])));
        rsp.col_one  = sat_word(ACC_W'($signed(mat.tup[1])));
        rsp.col_two  = sat_word(ACC_W'($signed(mat.fwd[1])));
      end
      2'd2: begin
        rsp.col_zero = sat_word(ACC_W'($signed(mat.side[2])));
        rsp.col_one  = sat_word(ACC_W'($signed(mat.tup[2])));
        rsp.col_two  = sat_word(ACC_W'($signed(mat.fwd[2])));
      end
      default: begin
        rsp.col_zero  = mat.dot[0];
        rsp.col_one   = mat.dot[1];
        rsp.col_two   = mat.dot[2];
        rsp.col_three = ONE;
      end
    endcase
    if (mat.degen) begin
      rsp.col_zero  = (row == 2'd0) ? ONE : '0;
      rsp.col_one   = (row == 2'd1) ? ONE : '0;
      rsp.col_two   = (row == 2'd2) ? ONE : '0;
      rsp.col_three = (row == 2'd3) ? ONE : '0;
    end
  end

endmodule

### src/look_at_view_matrix_unit.sv
// ----------------------------------------------------------------------------
// look_at_view_matrix_unit
// World-to-view matrix from eye, look-at point and up vector, Q16.16.
// ----------------------------------------------------------------------------
//  channel  signals                     item
//  request  req_valid, req_ready, req   eye, at, up vectors
//  rows     rsp_valid, rsp_ready, rsp   one matrix row, four per request
//
//  The back end normalises forward and then side, each by scaling shifts,
//  squares, one root and three divides, using the shared one-bit-per-cycle
//  square root and divider and the single multiply-accumulate path. Up
//  parallel to forward ends when the side cross product is zero, eye equal
//  to at ends without computing. A two-entry queue takes items while the
//  back end works, and a finished matrix waits in the row emitter while the
//  next item is computed. Reset is synchronous and clears control state.
// ----------------------------------------------------------------------------
module look_at_view_matrix_unit import lav_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  lav_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output lav_rsp_t rsp
);

  logic     full;
  logic     push;
  lav_job_t job_in;
  lav_job_t job_out;
  logic     avail;
  logic     pop;
  logic     emit_busy;
  logic     mat_load;
  lav_mat_t mat;

  lav_front u_front (
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .full     (full),
    .push     (push),
    .job      (job_in)
  );

  lav_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .job_in (job_in),
    .full   (full),
    .pop    (pop),
    .job_out(job_out),
    .avail  (avail)
  );

  lav_back u_back (
    .clk      (clk),
    .rst      (rst),
    .job_avail(avail),
    .job      (job_out),
    .job_pop  (pop),
    .emit_busy(emit_busy),
    .mat_load (mat_load),
    .mat      (mat)
  );

  lav_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .load     (mat_load),
    .mat_in   (mat),
    .busy     (emit_busy),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

endmodule

### tb/look_at_view_matrix_unit_tb.sv
// ----------------------------------------------------------------------------
// look_at_view_matrix_unit_tb
// Self-checking bench for the look-at view matrix unit. Each item is checked
// against a software predictor of the row-major view matrix (normalisation,
// cross products, eye dot products, saturation and the identity fallback).
// Random handshake gaps on both channels, long result hold-off, drain pause.
// ----------------------------------------------------------------------------
module look_at_view_matrix_unit_tb import lav_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 500000;

  typedef longint vec3_t [3];

  logic     clk;
  logic     rst;
  logic     req_valid;
  logic     req_ready;
  lav_req_t req;
  logic     rsp_valid;
  logic     rsp_ready = 1'b0;
  lav_rsp_t rsp;

  lav_rsp_t row_q[$];
  int       errors = 0;
  int       cycles = 0;
  int       hold_cycles = 0;
  bit       hold_req;
  bit       hold_seen;
  bit       steady;

  look_at_view_matrix_unit u_top (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint unsigned magn(longint x);
    return x < 0 ? longint'(-x) : x;
  endfunction

  function automatic longint rnd16(longint x);
    longint unsigned m;
    m = (magn(x) + 64'd32768) >> FRAC;
    return x < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic [31:0] clamp32(longint x);
    if (x > 64'sd2147483647) return 32'h7fff_ffff;
    if (x < -64'sd2147483648) return 32'h8000_0000;
    return x[31:0];
  endfunction

  function automatic longint unsigned sqrt_floor(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic bit to_unit(inout vec3_t v);
    longint unsigned m[3], top, len, q;
    for (int i = 0; i < 3; i++) m[i] = magn(v[i]);
    top = m[0];
    if (m[1] > top) top = m[1];
    if (m[2] > top) top = m[2];
    if (top == 0) return 1'b0;
    while (top >= (64'd1 << 30)) begin
      top >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    while (top < (64'd1 << 29)) begin
      top <<= 1;
      for (int i = 0; i < 3; i++) m[i] <<= 1;
    end
    len = sqrt_floor(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << FRAC) + (len >> 1)) / len;
      v[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  function automatic longint neg_dot(vec3_t a, vec3_t b);
    return -rnd16(a[0] * b[0] + a[1] * b[1] + a[2] * b[2]);
  endfunction

  task automatic predict_view_rows(lav_req_t r);
    vec3_t    eye, upv, fwd, side, tup;
    bit       degen;
    lav_rsp_t row;
    eye = '{longint'(r.eye_x), longint'(r.eye_y), longint'(r.eye_z)};
    upv = '{longint'(r.up_x), longint'(r.up_y), longint'(r.up_z)};
    fwd = '{longint'(r.at_x) - eye[0], longint'(r.at_y) - eye[1],
            longint'(r.at_z) - eye[2]};
    degen = !to_unit(fwd);
    if (!degen) begin
      side[0] = upv[1] * fwd[2] - upv[2] * fwd[1];
      side[1] = upv[2] * fwd[0] - upv[0] * fwd[2];
      side[2] = upv[0] * fwd[1] - upv[1] * fwd[0];
      degen = !to_unit(side);
    end
    if (!degen) begin
      tup[0] = rnd16(fwd[1] * side[2] - fwd[2] * side[1]);
      tup[1] = rnd16(fwd[2] * side[0] - fwd[0] * side[2]);
      tup[2] = rnd16(fwd[0] * side[1] - fwd[1] * side[0]);
    end
    for (int i = 0; i < 4; i++) begin
      row.row_index  = 2'(i);
      row.degenerate = degen;
      row.last_row   = (i == 3);
      if (degen) begin
        row.col_zero  = (i == 0) ? ONE : '0;
        row.col_one   = (i == 1) ? ONE : '0;
        row.col_two   = (i == 2) ? ONE : '0;
        row.col_three = (i == 3) ? ONE : '0;
      end else if (i < 3) begin
        row.col_zero  = clamp32(side[i]);
        row.col_one   = clamp32(tup[i]);
        row.col_two   = clamp32(fwd[i]);
        row.col_three = '0;
      end else begin
        row.col_zero  = clamp32(neg_dot(eye, side));
        row.col_one   = clamp32(neg_dot(eye, tup));
        row.col_two   = clamp32(neg_dot(eye, fwd));
        row.col_three = ONE;
      end
      row_q.push_back(row);
    end
  endtask

  // ---------------------------------------------------------------- checking
  task automatic cmp_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s expected %h, got %h", $realtime, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
    if (!rst && rsp_valid && rsp_ready) begin
      if (row_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected row, expected none, got %h", $realtime, rsp);
      end else begin
        lav_rsp_t e;
        e = row_q.pop_front();
        cmp_field("row_index", e.row_index, rsp.row_index);
        cmp_field("col_zero", e.col_zero, rsp.col_zero);
        cmp_field("col_one", e.col_one, rsp.col_one);
        cmp_field("col_two", e.col_two, rsp.col_two);
        cmp_field("col_three", e.col_three, rsp.col_three);
        cmp_field("degenerate", e.degenerate, rsp.degenerate);
        cmp_field("last_row", e.last_row, rsp.last_row);
      end
    end
  end

  // result side: random stalls, or a counted hold-off
  always @(negedge clk) begin
    if (hold_req && !hold_seen) begin
      hold_seen   <= 1'b1;
      rsp_ready   <= 1'b0;
      hold_cycles <= 1500;
    end else if (hold_cycles > 0) begin
      rsp_ready   <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      rsp_ready <= steady ? 1'b1 : ($urandom_range(99) >= 37);
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic send_item(lav_req_t r);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 37) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (!req_ready);
    predict_view_rows(r);
  endtask

  function automatic lav_req_t mk_req(longint ex, longint ey, longint ez,
                                      longint ax, longint ay, longint az,
                                      longint ux, longint uy, longint uz);
    lav_req_t r;
    r = '{ex[31:0], ey[31:0], ez[31:0], ax[31:0], ay[31:0], az[31:0],
          ux[31:0], uy[31:0], uz[31:0]};
    return r;
  endfunction

  function automatic logic [31:0] srand_bits(int bits);
    return 32'($signed(64'($urandom) << 32 | 64'($urandom)) >>> (64 - bits));
  endfunction

  function automatic lav_req_t camera_req();
    lav_req_t r;
    int       sel;
    sel = $urandom_range(99);
    if (sel < 15) begin
      r = lav_req_t'({$urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom});
    end else begin
      int eb, db;
      eb = $urandom_range(31, 4);
      db = $urandom_range(31, 2);
      r.eye_x = srand_bits(eb);
      r.eye_y = srand_bits(eb);
      r.eye_z = srand_bits(eb);
      r.at_x  = r.eye_x + srand_bits(db);
      r.at_y  = r.eye_y + srand_bits(db);
      r.at_z  = r.eye_z + srand_bits(db);
      if (sel < 60) begin
        r.up_x = srand_bits(12);
        r.up_y = 32'sd65536 + srand_bits(14);
        r.up_z = srand_bits(12);
      end else begin
        r.up_x = srand_bits($urandom_range(32, 2));
        r.up_y = srand_bits($urandom_range(32, 2));
        r.up_z = srand_bits($urandom_range(32, 2));
      end
      if (sel >= 90 && sel < 95) begin
        r.at_x = r.eye_x; r.at_y = r.eye_y; r.at_z = r.eye_z;
      end else if (sel >= 95) begin
        r.up_x = r.at_x - r.eye_x; r.up_y = r.at_y - r.eye_y; r.up_z = r.at_z - r.eye_z;
      end
    end
    return r;
  endfunction

  task automatic wait_drained();
    @(negedge clk);
    req_valid <= 1'b0;
    while (row_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_special_cases();
    // eye equal to at, zero up, up along forward, up opposite forward, one small-offset view
    send_item(mk_req(0, 0, 0, 0, 0, 0, 0, 65536, 0));
    send_item(mk_req(12345, -777, 9, 12345, -777, 9, 0, 65536, 0));
    send_item(mk_req(0, 0, 0, 0, 0, -65536, 0, 0, 0));
    send_item(mk_req(0, 0, 0, 0, 65536, 0, 0, 131072, 0));
    send_item(mk_req(0, 0, 0, 0, 0, 65536, 0, 0, -1));
    send_item(mk_req(1, 2, 3, 1, 2, 65539, 5, 10, 15));
  endtask

  task automatic test_axis_views();
    send_item(mk_req(0, 0, 0, 0, 0, -65536, 0, 65536, 0));
    send_item(mk_req(0, 0, 327680, 0, 0, 0, 0, 65536, 0));
    send_item(mk_req(65536, 131072, 196608, 0, 0, 0, 0, 65536, 0));
    send_item(mk_req(0, 0, 0, 1, 0, 0, 0, 0, 1));
    send_item(mk_req(0, 0, 0, 65536, 65536, 65536, 65536, 0, 32768));
  endtask

  task automatic test_field_extremes();
    longint mx, mn;
    mx = 64'sd2147483647;
    mn = -64'sd2147483648;
    send_item(mk_req(mx, mx, mx, mn, mn, mn, 0, 65536, 0));
    send_item(mk_req(mn, mn, mn, mx, mx, mx, mn, mx, mn));
    send_item(mk_req(mx, mn, mx, mn, mx, mn, mx, mn, 1));
    send_item(mk_req(mx, mx, mx, mx, mx, mx - 1, mx, 0, 0));
    send_item(mk_req(mn, 0, 0, mn, 1, 0, 0, 0, mn));
    send_item(mk_req(mx, mx, mx, 0, 0, 0, 65536, 0, 0));
    send_item(mk_req(-1, -1, -1, 0, 0, 0, -1, 0, -1));
  endtask

  task automatic test_random_views(int count);
    for (int i = 0; i < count; i++) send_item(camera_req());
  endtask

  task automatic test_no_gaps(int count);
    steady = 1'b1;
    test_random_views(count);
    wait_drained();
    steady = 1'b0;
  endtask

  task automatic test_result_backpressure();
    @(negedge clk);
    hold_req = 1'b1;
    test_random_views(6);
    wait_drained();
  endtask

  task automatic test_pause_then_resume();
    wait_drained();
    repeat (300) @(posedge clk);
    test_random_views(10);
  endtask

  initial begin
    rst         = 1'b1;
    req_valid   = 1'b0;
    req         = '0;
    hold_req    = 1'b0;
    steady      = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_special_cases();
    test_axis_views();
    test_field_extremes();
    test_random_views(42);
    test_no_gaps(20);
    test_result_backpressure();
    test_pause_then_resume();
    test_random_views(24);

    @(negedge clk);
    req_valid <= 1'b0;
    wait_drained();
    repeat (400) @(posedge clk);
    if (errors == 0 && row_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
